// ===== src/ihex_pkg.sv =====
// Shared types, codes and character constants for the Intel HEX record encoder.
`default_nettype none
package ihex_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [3:0] EOF_LAST = 4'd10;
    localparam logic [3:0] HDR_LAST = 4'd7;

    localparam logic [7:0] EOF_TEXT [0:10] = '{
        8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31, 8'h46, 8'h46
    };

    localparam logic REG_END_ADDR = 1'b0;
    localparam logic REG_LINE_END = 1'b1;

    typedef enum logic [8:0] {
        P_COLON = 9'b000000001,
        P_HDR   = 9'b000000010,
        P_DATA  = 9'b000000100,
        P_SUM   = 9'b000001000,
        P_CR    = 9'b000010000,
        P_LF    = 9'b000100000,
        P_EOF   = 9'b001000000,
        P_ECR   = 9'b010000000,
        P_ELF   = 9'b100000000
    } t_phase;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        base = (nib < 4'd10) ? 8'h30 : 8'h37;
        return base + {4'b0, nib};
    endfunction

endpackage
`default_nettype wire

// ===== src/ihex_in_if.sv =====
// Input channel: one memory byte per beat with its read status.
`default_nettype none
interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       read_error;

    modport source (output valid, output data_byte, output read_error, input ready);
    modport sink   (input valid, input data_byte, input read_error, output ready);
endinterface
`default_nettype wire

// ===== src/ihex_out_if.sv =====
// Output channel: one ASCII character per beat with its flags.
`default_nettype none
interface ihex_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       run_last;
    logic       export_done;
    logic       export_error;

    modport source (output valid, output text_char, output run_last,
                    output export_done, output export_error, input ready);
    modport sink   (input valid, input text_char, input run_last,
                    input export_done, input export_error, output ready);
endinterface
`default_nettype wire

// ===== src/intel_hex_record_encoder_top.sv =====
// Intel HEX record encoder: memory bytes in, ASCII hex text out, one char per beat.
// Characters are formed from the registered byte and then registered for output.
// Throughput: one character per cycle unless the output stalls; a byte yields 2 to 19
// characters at 16 bytes per record (up to 28 at one byte per record), and the next
// byte is taken in the cycle its last character enters the one-character output register.
// Reset (synchronous, active low): export state clears, end_address = 511, CR/LF line ends.
`default_nettype none
module intel_hex_record_encoder_top #(
    parameter int RECORD_BYTES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ihex_in_if.sink     i_in,
    ihex_out_if.source  o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BIR_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam logic [7:0]     COUNT   = 8'(RECORD_BYTES);
    localparam logic [BIR_W:0] REC_LEN = (BIR_W + 1)'(RECORD_BYTES);

    // configuration
    logic [15:0] r_end_addr;
    logic        r_crlf;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ihex_pkg::REG_LINE_END) ? {31'b0, r_crlf}
                                                         : {16'b0, r_end_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_addr <= 16'd511;
            r_crlf     <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ihex_pkg::REG_END_ADDR) begin
                r_end_addr <= pwdata[15:0];
            end else begin
                r_crlf <= pwdata[0];
            end
        end
    end

    // export state
    logic [15:0]    r_addr;
    logic [7:0]     r_sum;
    logic [BIR_W-1:0] r_bir;

    // item being emitted
    logic            r_busy;
    ihex_pkg::t_phase r_phase;
    logic [3:0]      r_dig;
    logic [7:0]      r_data;
    logic            r_err;
    logic [15:0]     r_hdr_addr;
    logic [7:0]      r_chk;
    logic            r_rec_end;
    logic            r_eof;

    // output register
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_done;
    logic       r_eflag;

    logic             accept;
    logic             adv;
    logic             last;
    logic [7:0]       ch;
    logic             f_done;
    logic             f_err;
    ihex_pkg::t_phase n_phase;
    logic [3:0]       n_dig;
    ihex_pkg::t_phase eol_phase;
    ihex_pkg::t_phase eeol_phase;

    // per-item state update, done at the input beat
    logic [7:0]       hdr_sum;
    logic [7:0]       sum0;
    logic [7:0]       sum1;
    logic [BIR_W:0]   bir1;
    logic             rec_end;
    logic             eof_hit;
    logic [15:0]      n_addr;
    logic [7:0]       n_sum;
    logic [BIR_W-1:0] n_bir;

    always_comb begin
        hdr_sum = COUNT + r_addr[15:8] + r_addr[7:0];
        sum0    = (r_bir == '0) ? hdr_sum : r_sum;
        sum1    = sum0 + i_in.data_byte;
        bir1    = {1'b0, r_bir} + 1'b1;
        rec_end = (bir1 == REC_LEN);
        eof_hit = rec_end && (r_addr >= r_end_addr);
        if (i_in.read_error) begin
            n_addr = '0;
            n_sum  = '0;
            n_bir  = '0;
        end else if (rec_end) begin
            n_addr = eof_hit ? 16'd0 : r_addr + 16'd1;
            n_sum  = '0;
            n_bir  = '0;
        end else begin
            n_addr = r_addr + 16'd1;
            n_sum  = sum1;
            n_bir  = bir1[BIR_W-1:0];
        end
    end

    // character sequencer
    always_comb begin
        eol_phase  = r_crlf ? ihex_pkg::P_CR : ihex_pkg::P_LF;
        eeol_phase = r_crlf ? ihex_pkg::P_ECR : ihex_pkg::P_ELF;
        ch      = ihex_pkg::CH_LF;
        last    = 1'b0;
        f_done  = 1'b0;
        f_err   = 1'b0;
        n_phase = r_phase;
        n_dig   = r_dig + 4'd1;
        case (r_phase)
            ihex_pkg::P_COLON: begin
                ch      = ihex_pkg::CH_COLON;
                n_phase = ihex_pkg::P_HDR;
                n_dig   = '0;
            end
            ihex_pkg::P_HDR: begin
                case (r_dig[2:0])
                    3'd0:    ch = ihex_pkg::hex_char(COUNT[7:4]);
                    3'd1:    ch = ihex_pkg::hex_char(COUNT[3:0]);
                    3'd2:    ch = ihex_pkg::hex_char(r_hdr_addr[15:12]);
                    3'd3:    ch = ihex_pkg::hex_char(r_hdr_addr[11:8]);
                    3'd4:    ch = ihex_pkg::hex_char(r_hdr_addr[7:4]);
                    3'd5:    ch = ihex_pkg::hex_char(r_hdr_addr[3:0]);
                    default: ch = ihex_pkg::hex_char(4'd0);
                endcase
                if (r_dig == ihex_pkg::HDR_LAST) begin
                    n_phase = r_err ? eol_phase : ihex_pkg::P_DATA;
                    n_dig   = '0;
                end
            end
            ihex_pkg::P_DATA: begin
                ch = ihex_pkg::hex_char(r_dig[0] ? r_data[3:0] : r_data[7:4]);
                if (r_dig[0]) begin
                    last    = !r_rec_end;
                    n_phase = ihex_pkg::P_SUM;
                    n_dig   = '0;
                end
            end
            ihex_pkg::P_SUM: begin
                ch = ihex_pkg::hex_char(r_dig[0] ? r_chk[3:0] : r_chk[7:4]);
                if (r_dig[0]) begin
                    n_phase = eol_phase;
                end
            end
            ihex_pkg::P_CR: begin
                ch      = ihex_pkg::CH_CR;
                f_err   = r_err;
                n_phase = ihex_pkg::P_LF;
            end
            ihex_pkg::P_LF: begin
                ch      = ihex_pkg::CH_LF;
                f_err   = r_err;
                last    = r_err || !r_eof;
                n_phase = ihex_pkg::P_EOF;
                n_dig   = '0;
            end
            ihex_pkg::P_EOF: begin
                ch = ihex_pkg::EOF_TEXT[r_dig];
                if (r_dig == ihex_pkg::EOF_LAST) begin
                    n_phase = eeol_phase;
                end
            end
            ihex_pkg::P_ECR: begin
                ch      = ihex_pkg::CH_CR;
                n_phase = ihex_pkg::P_ELF;
            end
            ihex_pkg::P_ELF: begin
                ch     = ihex_pkg::CH_LF;
                last   = 1'b1;
                f_done = 1'b1;
            end
            default: begin
                ch = ihex_pkg::CH_LF;
            end
        endcase
    end

    assign adv        = r_busy && (!r_ov || o_out.ready);
    assign i_in.ready = !r_busy || (adv && last);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_sum   <= '0;
            r_bir   <= '0;
            r_busy  <= 1'b0;
            r_phase <= ihex_pkg::P_COLON;
            r_dig   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (accept) begin
                r_addr <= n_addr;
                r_sum  <= n_sum;
                r_bir  <= n_bir;
                r_busy <= 1'b1;
                r_dig  <= '0;
                if (r_bir == '0) begin
                    r_phase <= ihex_pkg::P_COLON;
                end else if (i_in.read_error) begin
                    r_phase <= eol_phase;
                end else begin
                    r_phase <= ihex_pkg::P_DATA;
                end
            end else if (adv) begin
                r_busy  <= !last;
                r_phase <= n_phase;
                r_dig   <= n_dig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data     <= i_in.data_byte;
            r_err      <= i_in.read_error;
            r_hdr_addr <= r_addr;
            r_chk      <= 8'd0 - sum1;
            r_rec_end  <= rec_end;
            r_eof      <= eof_hit;
        end
        if (adv) begin
            r_char  <= ch;
            r_last  <= last;
            r_done  <= f_done;
            r_eflag <= f_err;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.text_char    = r_char;
    assign o_out.run_last     = r_last;
    assign o_out.export_done  = r_done;
    assign o_out.export_error = r_eflag;

endmodule
`default_nettype wire
